### hw/rtl/tar_archive_entry_walker_assert.svh
// assertion macros for the tar archive entry walker
`ifndef TAR_ARCHIVE_ENTRY_WALKER_ASSERT_SVH
`define TAR_ARCHIVE_ENTRY_WALKER_ASSERT_SVH

// same-cycle implication, held off during reset
`define TAEW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tar walker check failed");

// next-cycle implication, held off during reset
`define TAEW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tar walker check failed");

`endif

### hw/rtl/taew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taew_pkg
// Shared types and constants of the tar archive entry walker.
// ----------------------------------------------------------------------------
package taew_pkg;

    // header layout
    localparam int unsigned SIZE_DIGITS_DEF = 11;
    localparam logic [8:0]  SIZE_FIELD_AT   = 9'd124;
    localparam logic [8:0]  TYPE_FIELD_AT   = 9'd156;
    localparam logic [8:0]  BLOCK_LAST      = 9'd511;
    localparam logic [31:0] BLOCK_BYTES     = 32'd512;

    // characters of the size and type fields
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // one input beat
    typedef struct packed {
        logic [7:0] archive_byte;
        logic       start_req;
    } t_in_item;

    // one result beat
    typedef struct packed {
        logic [23:0] entry_index;
        logic [31:0] header_address;
        logic [31:0] data_address;
        logic [31:0] file_size;
        logic [7:0]  type_byte;
        logic        is_regular;
        logic        end_of_archive;
    } t_out_item;

    // control from the beat register to the walk logic
    typedef struct packed {
        logic present;   // a byte sits in the beat register
        logic commit;    // the byte is consumed this cycle
    } t_step_ctl;

endpackage

### hw/rtl/taew_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taew_walk
// Walk state of the archive and its per-byte update: block offset, phase,
// octal size parse, type byte, data block skip and the header result.
// ----------------------------------------------------------------------------
module taew_walk #(
    parameter int unsigned SIZE_DIGITS = taew_pkg::SIZE_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  taew_pkg::t_step_ctl i_ctl,
    input  taew_pkg::t_in_item  i_item,
    input  logic [31:0]         i_base,
    output logic                o_emit,
    output taew_pkg::t_out_item o_result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_ENDED  = 2'd2;

    localparam logic [8:0] SIZE_END = 9'(32'(taew_pkg::SIZE_FIELD_AT) + SIZE_DIGITS);

    logic [8:0]  r_off,    n_off;
    logic [1:0]  r_phase,  n_phase;
    logic [23:0] r_skip,   n_skip;
    logic [31:0] r_size,   n_size;
    logic        r_stop,   n_stop;
    logic        r_nempty, n_nempty;
    logic [7:0]  r_type,   n_type;
    logic [23:0] r_rcount, n_rcount;
    logic [31:0] r_hoff,   n_hoff;

    logic [7:0]  w_byte;
    logic [23:0] w_blocks;
    logic [23:0] w_blocks_p1;
    logic [23:0] w_skip_dec;
    logic [31:0] w_haddr;
    logic        w_reg;
    logic        w_emit;
    taew_pkg::t_out_item w_res;

    assign w_byte = i_item.archive_byte;

    // next state and result for the byte in the beat register
    always_comb begin
        n_off    = r_off;
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_size   = r_size;
        n_stop   = r_stop;
        n_nempty = r_nempty;
        n_type   = r_type;
        n_rcount = r_rcount;
        n_hoff   = r_hoff;
        w_emit   = 1'b0;
        w_res    = '0;

        // restart clears the walk before the byte is taken
        if (i_item.start_req) begin
            n_off    = '0;
            n_phase  = PH_HEADER;
            n_skip   = '0;
            n_size   = '0;
            n_stop   = 1'b0;
            n_nempty = 1'b0;
            n_type   = '0;
            n_rcount = '0;
            n_hoff   = '0;
        end

        w_blocks    = {1'b0, n_size[31:9]} + 24'(|n_size[8:0]);
        w_blocks_p1 = w_blocks + 24'd1;
        w_skip_dec  = n_skip - 24'd1;
        w_haddr     = i_base + n_hoff;
        w_reg       = (n_type == taew_pkg::CH_ZERO) || (n_type == taew_pkg::CH_NUL);

        case (n_phase)
            PH_HEADER: begin
                // first name byte opens a fresh header
                if (n_off == '0) begin
                    n_nempty = (w_byte == taew_pkg::CH_NUL);
                    n_size   = '0;
                    n_stop   = 1'b0;
                    n_type   = '0;
                end
                // octal size field
                if (n_off >= taew_pkg::SIZE_FIELD_AT && n_off < SIZE_END && !n_stop) begin
                    if (w_byte == taew_pkg::CH_NUL || w_byte == taew_pkg::CH_SPACE) begin
                        n_stop = 1'b1;
                    end else if (w_byte >= taew_pkg::CH_ZERO &&
                                 w_byte <= taew_pkg::CH_SEVEN) begin
                        n_size = {n_size[28:0], 3'b000} + {29'd0, w_byte[2:0]};
                    end
                end
                if (n_off == taew_pkg::TYPE_FIELD_AT) begin
                    n_type = w_byte;
                end
                // end of header block
                if (n_off == taew_pkg::BLOCK_LAST) begin
                    w_emit = (i_base != '0);
                    if (n_nempty) begin
                        w_res.end_of_archive = 1'b1;
                        n_phase = PH_ENDED;
                    end else begin
                        w_res.entry_index    = n_rcount;
                        w_res.header_address = w_haddr;
                        w_res.data_address   = w_haddr + taew_pkg::BLOCK_BYTES;
                        w_res.file_size      = n_size;
                        w_res.type_byte      = n_type;
                        w_res.is_regular     = w_reg;
                        if (w_reg) begin
                            n_rcount = n_rcount + 24'd1;
                        end
                        n_hoff  = n_hoff + {w_blocks_p1[22:0], 9'd0};
                        n_skip  = w_blocks;
                        n_phase = (w_blocks != '0) ? PH_DATA : PH_HEADER;
                    end
                end
                n_off = n_off + 9'd1;
            end
            PH_DATA: begin
                // count down the data blocks of the entry
                if (n_off == taew_pkg::BLOCK_LAST) begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                n_off = n_off + 9'd1;
            end
            default: begin
                // archive ended: bytes are dropped until a restart
            end
        endcase
    end

    // walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off    <= '0;
            r_phase  <= PH_HEADER;
            r_skip   <= '0;
            r_size   <= '0;
            r_stop   <= 1'b0;
            r_nempty <= 1'b0;
            r_type   <= '0;
            r_rcount <= '0;
            r_hoff   <= '0;
        end else if (i_ctl.commit) begin
            r_off    <= n_off;
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_size   <= n_size;
            r_stop   <= n_stop;
            r_nempty <= n_nempty;
            r_type   <= n_type;
            r_rcount <= n_rcount;
            r_hoff   <= n_hoff;
        end
    end

    assign o_emit   = i_ctl.present && w_emit;
    assign o_result = w_res;

endmodule

### hw/rtl/tar_archive_entry_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_archive_entry_walker
// Walks a tar archive byte stream and reports one result per header block while the base is nonzero.
//
//   channel   direction  signals
//   in        sink       i_in_valid / o_in_ready / i_in_data
//   out       source     o_out_valid / i_out_ready / o_out_data
//   cfg       sink       i_cfg_we / i_cfg_wdata (base address)
//
// One byte per cycle while no held result stalls it: a beat register feeds the
// walk logic, whose result goes to an output register. The result of the byte
// that closes a header is presented from the output register.
// A stalled result blocks only the byte that would make the next result.
// Synchronous active-low reset clears the walk, the count and the base.
// ----------------------------------------------------------------------------
`include "tar_archive_entry_walker_assert.svh"

module tar_archive_entry_walker #(
    parameter int unsigned SIZE_DIGITS = taew_pkg::SIZE_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  taew_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output taew_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);

    logic                r_base;
    logic [31:0]         r_base_addr;
    logic                r_in_valid;
    taew_pkg::t_in_item  r_in;
    logic                r_out_valid;
    taew_pkg::t_out_item r_out;

    logic                w_emit;
    logic                w_proc;
    taew_pkg::t_step_ctl w_ctl;
    taew_pkg::t_out_item w_res;

    // base address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr <= '0;
            r_base      <= 1'b0;
        end else if (i_cfg_we) begin
            r_base_addr <= i_cfg_wdata;
            r_base      <= (i_cfg_wdata != '0);
        end
    end

    // byte moves on unless its result would overrun a held result
    assign w_proc     = r_in_valid && (!w_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_proc;

    assign w_ctl = '{present: r_in_valid, commit: w_proc};

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    taew_walk #(
        .SIZE_DIGITS(SIZE_DIGITS)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_item  (r_in),
        .i_base  (r_base_addr),
        .o_emit  (w_emit),
        .o_result(w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `TAEW_ASSERT_NOW(a_emit_needs_base, i_clk, i_rst_n, w_emit, r_base)
    `TAEW_ASSERT_NOW(a_no_result_overrun, i_clk, i_rst_n, w_proc && w_emit, !r_out_valid || i_out_ready)
    `TAEW_ASSERT_NOW(a_end_fields_zero, i_clk, i_rst_n, r_out_valid && r_out.end_of_archive, r_out.file_size == '0 && r_out.header_address == '0)
    `TAEW_ASSERT_NEXT(a_beat_held, i_clk, i_rst_n, r_in_valid && !w_proc, r_in_valid && $stable(r_in))

endmodule
